/* src/omt_pkg.sv */
// Shared constants and types for the object motion tracker.
package omt_pkg;

    localparam int HISTORY_DEPTH   = 5;
    localparam int SLOPE_FRAC_BITS = 8;
    localparam int COORD_W         = 11;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int TRAVEL_W        = 12;
    localparam int HEADING_W       = 2;
    localparam int SLOPE_W         = 16;
    localparam int THRESH_W        = 12;
    localparam int QUEUE_DEPTH     = 2;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIV_W  = COORD_W + SLOPE_FRAC_BITS;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(16);

    localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 16'h7FFF;
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 16'h8000;

    localparam logic [HEADING_W-1:0] HEAD_SE = 2'd0;
    localparam logic [HEADING_W-1:0] HEAD_NE = 2'd1;
    localparam logic [HEADING_W-1:0] HEAD_NW = 2'd2;
    localparam logic [HEADING_W-1:0] HEAD_SW = 2'd3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // One classified position, handed from front to back.
    typedef struct packed {
        logic                     ready_res;
        logic                     found;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } omt_cmd_t;

    // One result; the last member sits in the lowest bits.
    typedef struct packed {
        logic                      slope_saturated;
        logic signed [SLOPE_W-1:0] slope;
        logic                      moving;
        logic [HEADING_W-1:0]      heading;
        logic [TRAVEL_W-1:0]       travel;
        logic                      found;
        logic                      ready_res;
    } omt_res_t;

    localparam int RES_W = $bits(omt_res_t);

endpackage

/* src/omt_front.sv */
// Front end: position history and per-beat difference to the oldest entry.
module omt_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [omt_pkg::COORD_W-1:0]       pos_x,
    input  logic [omt_pkg::COORD_W-1:0]       pos_y,
    output logic                              push,
    output omt_pkg::omt_cmd_t                 push_cmd,
    input  logic                              q_full
);
    import omt_pkg::*;

    logic [COORD_W-1:0] hist_x_reg [HISTORY_DEPTH];
    logic [COORD_W-1:0] hist_y_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               full_hist;

    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;
    assign full_hist = (fill_reg == FILL_W'(HISTORY_DEPTH));

    always_comb begin
        push_cmd.ready_res = full_hist;
        push_cmd.found     = (pos_x != '0) && (pos_y != '0);
        push_cmd.dx        = signed'({1'b0, pos_x}) - signed'({1'b0, hist_x_reg[slot_reg]});
        push_cmd.dy        = signed'({1'b0, pos_y}) - signed'({1'b0, hist_y_reg[slot_reg]});
    end

    always_comb begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (push) begin
            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (!full_hist) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            fill_reg <= '0;
        end else begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            hist_x_reg[slot_reg] <= pos_x;
            hist_y_reg[slot_reg] <= pos_y;
        end
    end

endmodule

/* src/omt_queue.sv */
// Short command queue between front and back.
module omt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  omt_pkg::omt_cmd_t    din,
    output logic                 full,
    input  logic                 pop,
    output omt_pkg::omt_cmd_t    dout,
    output logic                 empty
);
    import omt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    omt_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg;

    assign full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* src/omt_back.sv */
// Back end: travel, heading, moving flag, serial slope divider, output register.
module omt_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [omt_pkg::THRESH_W-1:0]   cfg_wr_data,
    input  logic                           q_empty,
    input  omt_pkg::omt_cmd_t              q_dout,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output omt_pkg::omt_res_t              out_res
);
    import omt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                state_reg;
    logic [THRESH_W-1:0]   thresh_reg;
    logic                  cur_ready_reg, cur_found_reg;
    logic [TRAVEL_W-1:0]   held_travel_reg;
    logic [HEADING_W-1:0]  held_heading_reg;
    logic                  held_moving_reg;
    logic [SLOPE_W-1:0]    held_slope_reg;
    logic                  held_sat_reg;
    logic [COORD_W-1:0]    rem_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [COORD_W-1:0]    dvs_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    omt_res_t              out_res_reg;

    logic [COORD_W-1:0]    adx, ady;
    logic [TRAVEL_W-1:0]   travel;
    logic [HEADING_W-1:0]  heading;
    logic                  moving;
    logic [COORD_W:0]      trial;
    logic                  ge;
    logic [31:0]           quo_ext;
    logic                  out_free;

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || out_ready;

    // Difference magnitudes fit in COORD_W bits.
    always_comb begin
        adx = q_dout.dx[DIFF_W-1] ? COORD_W'(-q_dout.dx) : COORD_W'(q_dout.dx);
        ady = q_dout.dy[DIFF_W-1] ? COORD_W'(-q_dout.dy) : COORD_W'(q_dout.dy);
        travel = TRAVEL_W'({1'b0, adx}) + TRAVEL_W'({1'b0, ady});
        moving = travel > thresh_reg;
        priority if (q_dout.dx > 0 && q_dout.dy > 0) begin
            heading = HEAD_SE;
        end else if (q_dout.dx > 0 && q_dout.dy < 0) begin
            heading = HEAD_NE;
        end else if (q_dout.dx < 0 && q_dout.dy < 0) begin
            heading = HEAD_NW;
        end else begin
            heading = HEAD_SW;
        end
    end

    // One restoring-division step per cycle.
    assign trial   = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = trial >= {1'b0, dvs_reg};
    assign quo_ext = 32'(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            thresh_reg       <= THRESH_RESET;
            held_travel_reg  <= '0;
            held_heading_reg <= HEAD_SE;
            held_moving_reg  <= 1'b0;
            held_slope_reg   <= '0;
            held_sat_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
            if (state_reg == S_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        if (q_dout.ready_res && moving && adx != '0) begin
                            state_reg <= S_DIV;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                        if (q_dout.ready_res) begin
                            held_travel_reg  <= travel;
                            held_heading_reg <= heading;
                            held_moving_reg  <= moving;
                            if (moving && adx == '0) begin
                                held_sat_reg <= 1'b1;
                                if (q_dout.dy > 0) begin
                                    held_slope_reg <= SLOPE_POS_MAX;
                                end else if (q_dout.dy < 0) begin
                                    held_slope_reg <= SLOPE_NEG_MAX;
                                end else begin
                                    held_slope_reg <= '0;
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    state_reg <= S_EMIT;
                    if (!neg_reg) begin
                        if (quo_ext > 32'd32767) begin
                            held_slope_reg <= SLOPE_POS_MAX;
                            held_sat_reg   <= 1'b1;
                        end else begin
                            held_slope_reg <= quo_ext[SLOPE_W-1:0];
                            held_sat_reg   <= 1'b0;
                        end
                    end else begin
                        if (quo_ext > 32'd32768) begin
                            held_slope_reg <= SLOPE_NEG_MAX;
                            held_sat_reg   <= 1'b1;
                        end else begin
                            held_slope_reg <= -quo_ext[SLOPE_W-1:0];
                            held_sat_reg   <= 1'b0;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Divider datapath and result payload.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && !q_empty) begin
            cur_ready_reg <= q_dout.ready_res;
            cur_found_reg <= q_dout.found;
            rem_reg       <= '0;
            quo_reg       <= DIV_W'(ady) << SLOPE_FRAC_BITS;
            dvs_reg       <= adx;
            neg_reg       <= q_dout.dx[DIFF_W-1] != q_dout.dy[DIFF_W-1];
            cnt_reg       <= CNT_W'(DIV_W - 1);
        end
        if (state_reg == S_DIV) begin
            rem_reg <= ge ? COORD_W'(trial - {1'b0, dvs_reg}) : trial[COORD_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == S_EMIT && out_free) begin
            out_res_reg.ready_res       <= cur_ready_reg;
            out_res_reg.found           <= cur_found_reg;
            out_res_reg.travel          <= held_travel_reg;
            out_res_reg.heading         <= held_heading_reg;
            out_res_reg.moving          <= held_moving_reg;
            out_res_reg.slope           <= held_slope_reg;
            out_res_reg.slope_saturated <= held_sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* src/object_motion_tracker_top.sv */
// Top level of the object motion tracker: front, queue, back and port packing.
//
//  channel | dir | beat contents (low bit up)
//  --------+-----+------------------------------------------------------------
//  s_      | in  | pos_x[10:0], pos_y[21:11], zero pad to 24 bits
//  m_      | out | ready_res[0], found[1], travel[13:2], heading[15:14],
//          |     | moving[16], slope[32:17], slope_saturated[33], pad to 40
//  cfg_    | in  | motion_threshold[11:0], written when cfg_wr_en is high
//
// A beat passes the back end states IDLE and EMIT when no slope is computed, and
// IDLE, DIV, FIN and EMIT when it is: the serial restoring divider resolves one
// quotient bit per cycle, DIV_W bits in all (19 at 11-bit coords, 8 fraction bits).
// The front takes a new beat whenever the two-entry queue has room, so it
// keeps accepting while the back end divides or a result waits on m_tready.
// Reset is synchronous on aresetn low: history fill count, held results and
// threshold (16) return to their reset values; history contents are not cleared.
module object_motion_tracker_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [omt_pkg::IN_TDATA_W-1:0]      s_tdata,   // pos_x, pos_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [omt_pkg::OUT_TDATA_W-1:0]     m_tdata,   // ready_res, found, travel,
                                                           // heading, moving, slope,
                                                           // slope_saturated
    input  logic                                cfg_wr_en,
    input  logic [omt_pkg::THRESH_W-1:0]        cfg_wr_data // motion_threshold
);
    import omt_pkg::*;

    logic      push, q_full, q_empty, pop;
    omt_cmd_t  push_cmd, q_dout;
    omt_res_t  out_res;

    // Classify beats and track history.
    omt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .pos_x    (s_tdata[COORD_W-1:0]),
        .pos_y    (s_tdata[2*COORD_W-1:COORD_W]),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // Decouple front from the multi-cycle back end.
    omt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    // Compute motion fields, slope, and hold the result beat.
    omt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_dout      (q_dout),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res)
    );

    assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), out_res};

    // Until the history fills, held fields still carry their reset values.
    a_not_ready_held_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_res.ready_res) |->
            (out_res.travel == '0 && !out_res.moving && out_res.slope == '0
             && !out_res.slope_saturated))
        else $error("held fields changed before history filled");

    // No displacement means the fallback heading.
    a_zero_travel_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.ready_res && out_res.travel == '0) |->
            (out_res.heading == HEAD_SW && !out_res.moving))
        else $error("zero travel with wrong heading or moving set");

    // A saturated slope sits at one of the clip values.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.slope_saturated) |->
            (out_res.slope == SLOPE_POS_MAX || out_res.slope == SLOPE_NEG_MAX
             || out_res.slope == '0))
        else $error("saturated slope not at a clip value");

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("command queue overflow");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for object_motion_tracker_top: predictor scoreboard and stream drivers.
import omt_pkg::*;

class track_checker;
    logic [COORD_W-1:0]   hist_x [HISTORY_DEPTH];
    logic [COORD_W-1:0]   hist_y [HISTORY_DEPTH];
    int                   slot;
    int                   fill;
    logic [THRESH_W-1:0]  threshold;
    logic [TRAVEL_W-1:0]  last_travel;
    logic [HEADING_W-1:0] last_heading;
    logic                 last_moving;
    logic [SLOPE_W-1:0]   last_slope;
    logic                 last_clipped;
    omt_res_t             expected_motion [$];
    int                   errors;
    int                   checked;
    int                   moving_seen;
    int                   clipped_seen;

    function new();
        foreach (hist_x[i]) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
        end
        slot         = 0;
        fill         = 0;
        threshold    = THRESH_RESET;
        last_travel  = '0;
        last_heading = HEAD_SE;
        last_moving  = 1'b0;
        last_slope   = '0;
        last_clipped = 1'b0;
        errors       = 0;
        checked      = 0;
        moving_seen  = 0;
        clipped_seen = 0;
    endfunction

    // Advance the tracker state by one accepted position and queue its result.
    function void note_position(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int       dx;
        int       dy;
        int       adx;
        int       ady;
        int       quot;
        omt_res_t want;
        want       = '0;
        want.found = (x != 0) && (y != 0);
        if (fill >= HISTORY_DEPTH) begin
            dx  = int'(x) - int'(hist_x[slot]);
            dy  = int'(y) - int'(hist_y[slot]);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            want.ready_res = 1'b1;
            last_travel    = TRAVEL_W'(adx + ady);
            if (dx > 0 && dy > 0)
                last_heading = HEAD_SE;
            else if (dx > 0 && dy < 0)
                last_heading = HEAD_NE;
            else if (dx < 0 && dy < 0)
                last_heading = HEAD_NW;
            else
                last_heading = HEAD_SW;
            last_moving = (last_travel > threshold);
            if (last_moving) begin
                if (adx == 0) begin
                    // vertical move: no finite slope, clip toward the sign of dy
                    last_clipped = 1'b1;
                    if (dy > 0)
                        last_slope = SLOPE_POS_MAX;
                    else if (dy < 0)
                        last_slope = SLOPE_NEG_MAX;
                    else
                        last_slope = '0;
                end else begin
                    quot = (ady << SLOPE_FRAC_BITS) / adx;
                    if ((dx < 0) != (dy < 0))
                        quot = -quot;
                    last_clipped = 1'b0;
                    if (quot > 32767) begin
                        quot         = 32767;
                        last_clipped = 1'b1;
                    end else if (quot < -32768) begin
                        quot         = -32768;
                        last_clipped = 1'b1;
                    end
                    last_slope = SLOPE_W'(quot);
                end
            end
        end else begin
            fill++;
        end
        hist_x[slot] = x;
        hist_y[slot] = y;
        slot         = (slot + 1) % HISTORY_DEPTH;

        want.travel          = last_travel;
        want.heading         = last_heading;
        want.moving          = last_moving;
        want.slope           = last_slope;
        want.slope_saturated = last_clipped;
        if (want.ready_res && want.moving) begin
            moving_seen++;
            if (want.slope_saturated)
                clipped_seen++;
        end
        expected_motion.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch on result %0d: expected 'h%0h, actual 'h%0h",
                     $time, name, checked, want, got);
        end
    endfunction

    // Compare one result beat with the oldest queued expectation.
    function void check_result(logic [OUT_TDATA_W-1:0] beat);
        omt_res_t got;
        omt_res_t want;
        got = beat[RES_W-1:0];
        if (expected_motion.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual 'h%0h", $time, beat);
            return;
        end
        want = expected_motion.pop_front();
        compare_field("ready_res", 16'(want.ready_res), 16'(got.ready_res));
        compare_field("found", 16'(want.found), 16'(got.found));
        compare_field("travel", 16'(want.travel), 16'(got.travel));
        compare_field("heading", 16'(want.heading), 16'(got.heading));
        compare_field("moving", 16'(want.moving), 16'(got.moving));
        compare_field("slope", want.slope, got.slope);
        compare_field("slope_saturated", 16'(want.slope_saturated),
                      16'(got.slope_saturated));
        checked++;
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES  = 7;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [THRESH_W-1:0]    cfg_wr_data = '0;

    track_checker track;
    bit           no_idle      = 1'b0;   // suppress random gaps on both sides
    bit           hold_off_req = 1'b0;   // ask the sink for one long stall
    int           hold_left    = 0;
    int           cycle_count  = 0;

    // Directed positions: extremes, every heading, vertical moves, clipped
    // quotients, found edge cases and a travel equal to the threshold.
    int dir_x [23] = '{0, 2047, 100, 0, 500, 2047, 0, 100, 0, 501, 2047, 5,
                       100, 1, 2047, 2047, 13, 117, 0, 2047, 2031, 12, 400};
    int dir_y [23] = '{0, 2047, 100, 500, 0, 2047, 0, 300, 0, 2047, 0, 5,
                       300, 2047, 0, 0, 5, 300, 2047, 1000, 0, 4, 250};

    object_motion_tracker_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result sink: check each accepted beat, then pick tready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            track.check_result(m_tdata);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            // long back-pressure: the block must fill up and stall s_tready
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && (no_idle || $urandom_range(99) >= 25);
        end
    end

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 2047)
            return COORD_W'(2047);
        return COORD_W'(v);
    endfunction

    // Offer one position beat, with an optional random gap first; return at the
    // edge where it is accepted, leaving tvalid high for a back-to-back beat.
    task automatic send_position(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        while (!no_idle && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, y, x};
        do @(posedge aclk); while (!s_tready);
        track.note_position(x, y);
    endtask

    // Drop tvalid and hold until every queued result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (track.expected_motion.size() != 0);
    endtask

    // Write the threshold register; only called while the block is idle.
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en        <= 1'b0;
        track.threshold = value;
    endtask

    initial begin : stimulus
        logic [THRESH_W-1:0] phase_thresh [NUM_PHASES];
        int                  phase_items  [NUM_PHASES];
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [COORD_W-1:0]  back_x;
        logic [COORD_W-1:0]  back_y;
        int                  mode;

        track = new();
        phase_thresh = '{12'd0, 12'd4094, 12'd1, 12'd2047, 12'd16,
                         THRESH_W'($urandom_range(4094)), THRESH_W'($urandom_range(63))};
        phase_items  = '{140, 130, 140, 130, 140, 130, 140};

        // Start in reset, then release it for good.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset threshold.
        foreach (dir_x[i])
            send_position(COORD_W'(dir_x[i]), COORD_W'(dir_y[i]));
        drain_results();

        px = '0;
        py = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_threshold(phase_thresh[p]);
            no_idle = (p == 0);   // first random phase runs at full rate
            for (int i = 0; i < phase_items[p]; i++) begin
                if (p == 2 && i == 20)
                    hold_off_req = 1'b1;
                if (p == 2 && i == 80)
                    drain_results();   // sender pause until all results are back
                back_x = track.hist_x[track.slot];
                back_y = track.hist_y[track.slot];
                mode   = $urandom_range(99);
                if (mode < 45) begin
                    // smooth track: small drift from the last position
                    px = clamp_coord(int'(px) + int'($urandom_range(40)) - 20);
                    py = clamp_coord(int'(py) + int'($urandom_range(40)) - 20);
                end else if (mode < 70) begin
                    px = COORD_W'($urandom_range(2047));
                    py = COORD_W'($urandom_range(2047));
                end else if (mode < 80) begin
                    case ($urandom_range(3))
                        0: px = COORD_W'(0);
                        1: px = COORD_W'(1);
                        2: px = COORD_W'(2046);
                        default: px = COORD_W'(2047);
                    endcase
                    case ($urandom_range(3))
                        0: py = COORD_W'(0);
                        1: py = COORD_W'(1);
                        2: py = COORD_W'(2046);
                        default: py = COORD_W'(2047);
                    endcase
                end else if (mode < 88) begin
                    // vertical move against the compared position
                    px = back_x;
                    py = COORD_W'($urandom_range(2047));
                end else if (mode < 95) begin
                    // steep move: tiny dx, so the quotient tends to clip
                    px = clamp_coord(int'(back_x) + int'($urandom_range(2)) - 1);
                    py = COORD_W'($urandom_range(2047));
                end else begin
                    px = back_x;
                    py = back_y;
                end
                send_position(px, py);
            end
            drain_results();
        end
        no_idle = 1'b0;

        // Let any stray beat show up before the verdict.
        repeat (60) @(posedge aclk);

        $display("Checked %0d results over %0d threshold settings plus the reset value;",
                 track.checked, NUM_PHASES);
        $display("%0d moving results, %0d of them with a clipped slope.",
                 track.moving_seen, track.clipped_seen);
        if (track.errors == 0 && track.expected_motion.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
